/* hw/rtl/two_stacks_shared_memory_defines.svh */
// assertion macros shared by the rtl
`ifndef TWO_STACKS_SHARED_MEMORY_DEFINES_SVH
`define TWO_STACKS_SHARED_MEMORY_DEFINES_SVH

// same-cycle implication, held off during reset
`define TSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define TSS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/tss_pkg.sv */
package tss_pkg;

   localparam int DEPTH     = 256;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CAP_W     = 9;
   localparam int DATA_W    = 32;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;
   // wide enough for depth, capacities and their sum
   localparam int SUM_W     = (((ADDR_W + 1) > CAP_W) ? (ADDR_W + 1) : CAP_W) + 1;

   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CAP_ONE = 1'b0,
      REG_CAP_TWO = 1'b1
   } reg_index_type;

   function automatic logic [SUM_W-1:0] eff_cap_one(input logic [CAP_W-1:0] cap);
      logic [SUM_W-1:0] c;
      c = SUM_W'(cap);
      return (c > DEPTH_SUM) ? DEPTH_SUM : c;
   endfunction

   function automatic logic [SUM_W-1:0] eff_cap_two(input logic [CAP_W-1:0] cap,
                                                    input logic [SUM_W-1:0] c1);
      logic [SUM_W-1:0] c;
      logic [SUM_W-1:0] room;
      c    = SUM_W'(cap);
      room = DEPTH_SUM - c1;
      return (c > room) ? room : c;
   endfunction

   function automatic logic [CAP_W-1:0] clamp_count(input logic [CAP_W-1:0] cnt,
                                                    input logic [SUM_W-1:0] cap);
      return (SUM_W'(cnt) > cap) ? cap[CAP_W-1:0] : cnt;
   endfunction

endpackage

/* hw/rtl/tss_req_if.sv */
interface tss_req_if
   import tss_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic                     stack_sel;
   logic signed [DATA_W-1:0] push_value;

   modport source (output valid, op, stack_sel, push_value, input ready);
   modport sink   (input valid, op, stack_sel, push_value, output ready);
endinterface

/* hw/rtl/tss_rsp_if.sv */
interface tss_rsp_if
   import tss_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] data;
   logic [CAP_W-1:0]         count;

   modport source (output valid, status, data, count, input ready);
   modport sink   (input valid, status, data, count, output ready);
endinterface

/* hw/rtl/tss_ram.sv */
module tss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

/* hw/rtl/two_stacks_shared_memory.sv */
// channel  dir  transfer moves                      handshake
// req_chan in   op, stack_sel, push_value           valid/ready
// rsp_chan out  status, data, count                 valid/ready
// csr_*    in   cap_one / cap_two by csr_index      csr_we, no back-pressure
//
// one item per cycle while req_chan.ready is high: the result appears the cycle
// after the transfer in the output register; a peek reads the stack ram, whose
// registered read data is the result data.
// req_chan.ready is low only while a result waits and rsp_chan.ready is low.
// synchronous reset clears both counts, sets both capacities to 128;
// ram contents are left as they are.
`include "two_stacks_shared_memory_defines.svh"

module two_stacks_shared_memory
   import tss_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   tss_req_if.sink              req_chan,
   tss_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAP_W-1:0]     csr_wdata
);

   logic [CAP_W-1:0]    cap_one_ff, cap_one_in;
   logic [CAP_W-1:0]    cap_two_ff, cap_two_in;
   logic [CAP_W-1:0]    count_one_ff, count_one_in;
   logic [CAP_W-1:0]    count_two_ff, count_two_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic [CAP_W-1:0]    count_ff, count_in;
   logic                peek_hit_ff, peek_hit_in;

   logic [SUM_W-1:0]    c1, c2, c1_new, c2_new, cap_sel, pos, addr_full;
   logic [CAP_W-1:0]    cnt_sel, cnt_new;
   logic                fire, ready;
   logic                ram_we, ram_re, is_push;
   logic [ADDR_W-1:0]   ram_addr;
   logic [DATA_W-1:0]   ram_rdata;

   assign ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire  = req_chan.valid && ready;

   // effective capacities now and after a pending register write
   always_comb begin
      c1         = eff_cap_one(cap_one_ff);
      c2         = eff_cap_two(cap_two_ff, c1);
      cap_one_in = (csr_we && csr_index == REG_CAP_ONE) ? csr_wdata : cap_one_ff;
      cap_two_in = (csr_we && csr_index == REG_CAP_TWO) ? csr_wdata : cap_two_ff;
      c1_new     = eff_cap_one(cap_one_in);
      c2_new     = eff_cap_two(cap_two_in, c1_new);
   end

   // decode of the current item
   always_comb begin
      cnt_sel     = req_chan.stack_sel ? count_two_ff : count_one_ff;
      cap_sel     = req_chan.stack_sel ? c2 : c1;
      cnt_new     = cnt_sel;
      status_in   = ST_OK;
      data_in     = '0;
      peek_hit_in = 1'b0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      is_push     = 1'b0;
      case (op_type'(req_chan.op))
         OP_PUSH: begin
            is_push = 1'b1;
            if (SUM_W'(cnt_sel) >= cap_sel) begin
               status_in = ST_FULL;
            end else begin
               cnt_new = cnt_sel + 1'b1;
               ram_we  = fire;
            end
         end
         OP_POP: begin
            if (cnt_sel == '0) begin
               status_in = ST_EMPTY;
            end else begin
               cnt_new = cnt_sel - 1'b1;
            end
         end
         OP_PEEK: begin
            if (cnt_sel == '0) begin
               status_in = ST_EMPTY;
               data_in   = '1;
            end else begin
               peek_hit_in = 1'b1;
               ram_re      = fire;
            end
         end
         default: ;
      endcase
      count_in = cnt_new;
      // slot of the top entry: new top for a push, current top for a peek
      pos       = is_push ? SUM_W'(cnt_sel) : (SUM_W'(cnt_sel) - 1'b1);
      addr_full = req_chan.stack_sel ? (c1 + c2 - 1'b1 - pos) : pos;
      ram_addr  = addr_full[ADDR_W-1:0];
   end

   // counts: cut to capacity on a register write, else step on a transfer
   always_comb begin
      count_one_in = count_one_ff;
      count_two_in = count_two_ff;
      if (csr_we) begin
         count_one_in = clamp_count(count_one_ff, c1_new);
         count_two_in = clamp_count(count_two_ff, c2_new);
      end else if (fire) begin
         if (req_chan.stack_sel) begin
            count_two_in = cnt_new;
         end else begin
            count_one_in = cnt_new;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_one_ff   <= CAP_W'(128);
         cap_two_ff   <= CAP_W'(128);
         count_one_ff <= '0;
         count_two_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_one_ff   <= cap_one_in;
         cap_two_ff   <= cap_two_in;
         count_one_ff <= count_one_in;
         count_two_ff <= count_two_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff   <= status_in;
         data_ff     <= data_in;
         count_ff    <= count_in;
         peek_hit_ff <= peek_hit_in;
      end
   end

   tss_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (req_chan.push_value),
      .re    (ram_re),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   // ram read data holds while the result waits: no read without a transfer
   assign req_chan.ready  = ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.data   = peek_hit_ff ? ram_rdata : data_ff;
   assign rsp_chan.count  = count_ff;

   `TSS_ASSERT_IMP(a_count_one_cap, clock, reset, 1'b1, SUM_W'(count_one_ff) <= c1, "count one above capacity")
   `TSS_ASSERT_IMP(a_count_two_cap, clock, reset, 1'b1, SUM_W'(count_two_ff) <= c2, "count two above capacity")
   `TSS_ASSERT_IMP(a_no_ram_clash, clock, reset, 1'b1, !(ram_we && ram_re), "ram read and write together")
   `TSS_ASSERT_NXT(a_result_follows, clock, reset, fire, rsp_valid_ff && count_ff == $past(cnt_new), "result missing after transfer")
   `TSS_ASSERT_NXT(a_push_one_step, clock, reset, fire && !csr_we && ram_we && !req_chan.stack_sel, count_one_ff == $past(count_one_ff) + 1'b1, "stack one push did not advance")

endmodule

/* tb/two_stacks_shared_memory_checker.sv */
`timescale 1ns / 1ps

module two_stacks_shared_memory_checker
   import tss_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [OP_W-1:0]      req_op,
   input  logic                 req_stack_sel,
   input  logic [DATA_W-1:0]    req_push_value,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [STATUS_W-1:0]  rsp_status,
   input  logic [DATA_W-1:0]    rsp_data,
   input  logic [CAP_W-1:0]     rsp_count,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAP_W-1:0]     csr_wdata,
   output int                   mismatches,
   output int                   outstanding
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   data;
      logic [CAP_W-1:0]    count;
   } stack_outcome_type;

   logic [DATA_W-1:0] shadow_ram [DEPTH];
   int unsigned       fill_one;
   int unsigned       fill_two;
   int unsigned       cap_one_reg;
   int unsigned       cap_two_reg;
   stack_outcome_type due_outcomes [$];

   initial mismatches = 0;

   function automatic int unsigned room_one();
      return (cap_one_reg < DEPTH) ? cap_one_reg : DEPTH;
   endfunction

   // second stack only gets what the first one leaves
   function automatic int unsigned room_two();
      int unsigned spare;
      spare = DEPTH - room_one();
      return (cap_two_reg < spare) ? cap_two_reg : spare;
   endfunction

   function automatic stack_outcome_type apply_stack_op(input logic [OP_W-1:0] op,
                                                        input logic sel,
                                                        input logic [DATA_W-1:0] value);
      int unsigned       c1;
      int unsigned       c2;
      int unsigned       limit;
      int unsigned       cnt;
      int unsigned       slot;
      stack_outcome_type res;
      c1 = room_one();
      c2 = room_two();
      cnt = sel ? fill_two : fill_one;
      limit = sel ? c2 : c1;
      res.status = ST_OK;
      res.data = '0;
      case (op)
         OP_PUSH: begin
            if (cnt >= limit) begin
               res.status = ST_FULL;
            end else begin
               cnt++;
               slot = sel ? (c1 + c2 - cnt) : (cnt - 1);
               shadow_ram[slot] = value;
            end
         end
         OP_POP: begin
            if (cnt == 0) res.status = ST_EMPTY;
            else cnt--;
         end
         OP_PEEK: begin
            if (cnt == 0) begin
               res.status = ST_EMPTY;
               res.data = '1;
            end else begin
               slot = sel ? (c1 + c2 - cnt) : (cnt - 1);
               res.data = shadow_ram[slot];
            end
         end
         default: ;
      endcase
      if (sel) fill_two = cnt;
      else fill_one = cnt;
      res.count = cnt[CAP_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : watch
      stack_outcome_type got;
      stack_outcome_type want;
      if (reset) begin
         fill_one = 0;
         fill_two = 0;
         cap_one_reg = 128;
         cap_two_reg = 128;
         due_outcomes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_CAP_ONE: cap_one_reg = csr_wdata;
               REG_CAP_TWO: cap_two_reg = csr_wdata;
               default: ;
            endcase
            // counts are cut to the new room, stored words stay put
            if (fill_one > room_one()) fill_one = room_one();
            if (fill_two > room_two()) fill_two = room_two();
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_data, rsp_count};
            if (due_outcomes.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected rsp transfer: status %0d data %h count %0d",
                           $realtime, got.status, got.data, got.count);
               mismatches++;
            end else begin
               want = due_outcomes.pop_front();
               if (got !== want) begin
                  if (mismatches < 10)
                     $display("%0t: rsp mismatch: expected %0d %h %0d, got %0d %h %0d",
                              $realtime, want.status, want.data, want.count,
                              got.status, got.data, got.count);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            due_outcomes.push_back(apply_stack_op(req_op, req_stack_sel, req_push_value));
      end
      outstanding <= due_outcomes.size();
   end

endmodule

/* tb/two_stacks_shared_memory_tb.sv */
`timescale 1ns / 1ps

module two_stacks_shared_memory_tb;
   import tss_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int              SEL_ONE   = 0;
   localparam int              SEL_TWO   = 1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CAP_W-1:0]     csr_wdata;
   int                   mismatches;
   int                   outstanding;
   bit                   calm = 1'b0;
   bit                   hold_rsp = 1'b0;

   tss_req_if req_chan ();
   tss_rsp_if rsp_chan ();

   always #6 clock = ~clock;

   two_stacks_shared_memory dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   two_stacks_shared_memory_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_op         (req_chan.op),
      .req_stack_sel  (req_chan.stack_sel),
      .req_push_value (req_chan.push_value),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_status     (rsp_chan.status),
      .rsp_data       (rsp_chan.data),
      .rsp_count      (rsp_chan.count),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   // valid stays up between back-to-back items, only dropped for a gap
   task automatic send_op(input logic [OP_W-1:0] op, input int sel,
                          input logic [DATA_W-1:0] value);
      while (!calm && $urandom_range(0, 99) < 14) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.stack_sel  <= sel[0];
      req_chan.push_value <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_caps(input int unsigned first, input int unsigned second);
      drain();
      csr_we    <= 1'b1;
      csr_index <= REG_CAP_ONE;
      csr_wdata <= first[CAP_W-1:0];
      @(posedge clock);
      csr_index <= REG_CAP_TWO;
      csr_wdata <= second[CAP_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   // bursts lean towards push or pop, or stay even, so that both full and empty are reached
   task automatic random_run(input int items);
      int mode;
      int roll;
      int push_share;
      logic [OP_W-1:0] op;
      mode = 0;
      for (int i = 0; i < items; i++) begin
         if (i % 20 == 0) mode = $urandom_range(0, 2);
         push_share = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
         roll = $urandom_range(0, 99);
         if (roll < 2) op = OP_UNUSED;
         else if (roll < 2 + push_share * 98 / 100) op = OP_PUSH;
         else if ($urandom_range(0, 99) < 35) op = OP_PEEK;
         else op = OP_POP;
         send_op(op, $urandom_range(SEL_ONE, SEL_TWO), pick_value());
      end
   endtask

   // receiver side, with one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (60) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 14);
         end
      end
   end

   initial begin
      #2_400_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.op         = OP_PUSH;
      req_chan.stack_sel  = 1'b0;
      req_chan.push_value = '0;
      csr_we    = 1'b0;
      csr_index = REG_CAP_ONE;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty stacks at reset capacities
      send_op(OP_POP, SEL_ONE, '0);
      send_op(OP_PEEK, SEL_ONE, '0);
      send_op(OP_POP, SEL_TWO, '1);
      send_op(OP_PEEK, SEL_TWO, '0);
      send_op(OP_UNUSED, SEL_TWO, '0);

      // whole memory to the first stack: every word gets written once
      set_caps(256, 0);
      for (int i = 0; i < DEPTH; i++) send_op(OP_PUSH, SEL_ONE, $urandom());
      send_op(OP_PUSH, SEL_ONE, '1);
      send_op(OP_PUSH, SEL_TWO, '1);
      send_op(OP_PEEK, SEL_ONE, '0);
      send_op(OP_UNUSED, SEL_ONE, '1);

      // whole memory to the second stack, first count cut to zero
      set_caps(0, 256);
      send_op(OP_PUSH, SEL_ONE, '1);
      send_op(OP_PUSH, SEL_TWO, 32'h8000_0000);
      send_op(OP_PEEK, SEL_TWO, '0);
      send_op(OP_PUSH, SEL_TWO, 32'h7fff_ffff);
      send_op(OP_PUSH, SEL_TWO, '0);
      send_op(OP_PUSH, SEL_TWO, '1);
      send_op(OP_PEEK, SEL_TWO, '0);
      send_op(OP_POP, SEL_TWO, '0);
      send_op(OP_PEEK, SEL_TWO, '1);
      send_op(OP_UNUSED, SEL_TWO, '0);

      // oversized capacities saturate
      set_caps(511, 511);
      send_op(OP_PEEK, SEL_TWO, '0);
      send_op(OP_PEEK, SEL_ONE, '0);
      send_op(OP_PUSH, SEL_ONE, 32'h5a5a_a5a5);
      send_op(OP_PEEK, SEL_ONE, '0);

      set_caps(128, 128);
      random_run(160);
      set_caps(1, 1);
      random_run(160);
      set_caps(200, 100);
      random_run(160);

      // no gaps on either side, and the receiver holds off to fill the block
      set_caps(5, 300);
      calm = 1'b1;
      hold_rsp = 1'b1;
      random_run(160);
      calm = 1'b0;

      set_caps(256, 256);
      random_run(160);
      set_caps(0, 0);
      random_run(160);
      set_caps(100, 156);
      random_run(160);
      set_caps($urandom_range(0, 256), $urandom_range(0, 256));
      random_run(160);

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
